[hw/rtl/pair_key_hash_table_core_macros.svh]
// ----------------------------------------------------------------------------
// pair_key_hash_table_core_macros.svh
// Assertion macros for the hash table checker.
// ----------------------------------------------------------------------------
`ifndef PAIR_KEY_HASH_TABLE_CORE_MACROS_SVH
`define PAIR_KEY_HASH_TABLE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define PKHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PKHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pkht_pkg.sv]
// ----------------------------------------------------------------------------
// pkht_pkg
// Types and constants shared by the pair-key hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package pkht_pkg;

  localparam int NUM_BUCKETS = 1024;
  localparam int WAYS        = 4;

  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

  // djb2 over eight bytes stays below 2^53
  localparam int HASH_W     = 53;
  localparam int HASH_SHIFT = 5;
  localparam int MIX_STEPS  = (2 * KEY_W) / 8;
  localparam logic [HASH_W-1:0] HASH_INIT = HASH_W'(5381);

  localparam bit BKT_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
  localparam logic [BKT_W-1:0] BKT_MASK = BKT_W'(NUM_BUCKETS - 1);

  // other bucket counts: remainder kept per byte, t = 33 * r + byte,
  // r = t - floor(t * M / 2^S) * NUM_BUCKETS with M = ceil(2^S / NUM_BUCKETS)
  localparam int RED_T_W = BKT_W + 9;
  localparam int RED_S   = RED_T_W + BKT_W;
  localparam int RED_M_W = RED_T_W + 2;
  localparam int RED_Q_W = RED_T_W - BKT_W + 1;
  localparam longint unsigned RED_M_VAL =
    ((64'd1 << RED_S) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
  localparam logic [RED_M_W-1:0] RED_M    = RED_M_W'(RED_M_VAL);
  localparam logic [BKT_W-1:0]   RED_INIT = BKT_W'(5381 % NUM_BUCKETS);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] first_key;
    logic [KEY_W-1:0] second_key;
    logic [VAL_W-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] found_value;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] first_key;
    logic [KEY_W-1:0] second_key;
    logic [VAL_W-1:0] value;
  } slot_t;

  typedef slot_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic             done;
    logic [BKT_W-1:0] bucket;
  } hash_res_t;

  typedef struct packed {
    logic wr_en;
    rsp_t rsp;
  } bkt_res_t;

endpackage

`default_nettype wire

[hw/rtl/pkht_ram.sv]
// ----------------------------------------------------------------------------
// pkht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pkht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                            wr_data,
  input  wire logic                                        rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[hw/rtl/pkht_hash.sv]
// ----------------------------------------------------------------------------
// pkht_hash
// djb2 bucket hash: one key byte per cycle with a power-of-two bucket count;
// otherwise the remainder is kept per byte in mix, multiply, subtract steps.
// ----------------------------------------------------------------------------
`default_nettype none

module pkht_hash import pkht_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire req_t      req,
  output hash_res_t      res
);

  localparam int CNT_W  = (MIX_STEPS > 1) ? $clog2(MIX_STEPS) : 1;
  localparam int PROD_W = RED_T_W + RED_M_W;

  typedef enum logic [1:0] {H_IDLE, H_MIX, H_MUL, H_SUB} phase_t;

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [2*KEY_W-1:0] key_r, key_nxt;
  logic [HASH_W-1:0]  h_r, h_nxt;
  logic [RED_T_W-1:0] t_r, t_nxt;
  logic [RED_Q_W-1:0] q_r, q_nxt;
  logic [BKT_W-1:0]   rem_r, rem_nxt;
  logic               done_r, done_nxt;
  logic [BKT_W-1:0]   bkt_r, bkt_nxt;

  logic [HASH_W-1:0]  mix;
  logic [RED_T_W-1:0] red_t;
  logic [PROD_W-1:0]  red_prod;
  logic [RED_T_W-1:0] red_rem;

  assign mix      = (h_r << HASH_SHIFT) + h_r + HASH_W'(key_r[7:0]);
  assign red_t    = (RED_T_W'(rem_r) << HASH_SHIFT) + RED_T_W'(rem_r) +
                    RED_T_W'(key_r[7:0]);
  assign red_prod = PROD_W'(t_r) * PROD_W'(RED_M);
  assign red_rem  = t_r - RED_T_W'(q_r) * RED_T_W'(NUM_BUCKETS);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    h_nxt     = h_r;
    t_nxt     = t_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    bkt_nxt   = bkt_r;
    done_nxt  = 1'b0;
    unique case (phase_r)
      H_IDLE: begin
        if (start) begin
          key_nxt   = {req.second_key, req.first_key};
          h_nxt     = HASH_INIT;
          rem_nxt   = RED_INIT;
          cnt_nxt   = '0;
          phase_nxt = H_MIX;
        end
      end
      H_MIX: begin
        key_nxt = key_r >> 8;
        if (BKT_POW2) begin
          h_nxt   = mix;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(MIX_STEPS - 1)) begin
            done_nxt  = 1'b1;
            bkt_nxt   = mix[BKT_W-1:0] & BKT_MASK;
            phase_nxt = H_IDLE;
          end
        end else begin
          t_nxt     = red_t;
          phase_nxt = H_MUL;
        end
      end
      H_MUL: begin
        q_nxt     = red_prod[RED_S +: RED_Q_W];
        phase_nxt = H_SUB;
      end
      H_SUB: begin
        rem_nxt = red_rem[BKT_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MIX_STEPS - 1)) begin
          done_nxt  = 1'b1;
          bkt_nxt   = red_rem[BKT_W-1:0];
          phase_nxt = H_IDLE;
        end else begin
          phase_nxt = H_MIX;
        end
      end
      default: phase_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    key_r <= key_nxt;
    h_r   <= h_nxt;
    t_r   <= t_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    bkt_r <= bkt_nxt;
  end

  assign res = '{done: done_r, bucket: bkt_r};

endmodule

`default_nettype wire

[hw/rtl/pkht_bucket.sv]
// ----------------------------------------------------------------------------
// pkht_bucket
// Bucket row update: way match, free-way pick and the new row contents.
// ----------------------------------------------------------------------------
`default_nettype none

module pkht_bucket import pkht_pkg::*; (
  input  wire row_t  row,
  input  wire req_t  req,
  output row_t       row_new,
  output bkt_res_t   res
);

  logic             hit_found;
  logic [WAY_W-1:0] hit_idx;
  logic             free_found;
  logic [WAY_W-1:0] free_idx;

  always_comb begin
    hit_found  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (row[w].valid) begin
        if (!hit_found && row[w].first_key == req.first_key &&
            row[w].second_key == req.second_key) begin
          hit_found = 1'b1;
          hit_idx   = WAY_W'(w);
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        free_idx   = WAY_W'(w);
      end
    end
  end

  always_comb begin
    row_new = row;
    res     = '{wr_en: 1'b0, rsp: '{status: ST_MISSING, found_value: '0}};
    unique case (req.func)
      FUNC_INSERT: begin
        if (hit_found) begin
          row_new[hit_idx].value = req.new_value;
          res.wr_en              = 1'b1;
          res.rsp.status         = ST_OK;
        end else if (free_found) begin
          row_new[free_idx] = '{valid: 1'b1, first_key: req.first_key,
                                second_key: req.second_key, value: req.new_value};
          res.wr_en         = 1'b1;
          res.rsp.status    = ST_OK;
        end else begin
          res.rsp.status = ST_FULL;
        end
      end
      FUNC_DELETE: begin
        if (hit_found) begin
          row_new[hit_idx].valid = 1'b0;
          res.wr_en              = 1'b1;
          res.rsp.status         = ST_OK;
        end
      end
      FUNC_SEARCH: begin
        if (hit_found) begin
          res.rsp.status      = ST_OK;
          res.rsp.found_value = row[hit_idx].value;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/pair_key_hash_table_core.sv]
// ----------------------------------------------------------------------------
// pair_key_hash_table_core
// Flow: an accepted word is hashed byte by byte (djb2), its bucket row is
//   read and updated, and the response is registered to out_word.
// One word is taken at a time: in_stall stays high through the hash, the
//   bucket row read-modify-write and a stalled response.
// Reset: clears control, then a clearing pass writes zero to every bucket
//   row; in_stall stays high until it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_key_hash_table_core import pkht_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire req_t in_word,
  output logic      out_valid,
  input  wire logic out_stall,
  output rsp_t      out_word
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_MOD, S_RESP} state_t;

  state_t           state_r, state_nxt;
  logic [BKT_W-1:0] clr_r, clr_nxt;
  logic [BKT_W-1:0] addr_r, addr_nxt;
  req_t             req_r, req_nxt;
  rsp_t             rsp_r, rsp_nxt;
  logic             out_valid_r, out_valid_nxt;
  rsp_t             out_word_r, out_word_nxt;

  hash_res_t        hres;
  bkt_res_t         bres;
  row_t             rd_row;
  row_t             row_new;
  logic             hash_start;
  logic             ram_wr_en;
  logic [BKT_W-1:0] ram_wr_addr;
  logic [ROW_W-1:0] ram_wr_data;
  logic             ram_rd_en;

  assign in_stall   = (state_r != S_IDLE);
  assign hash_start = in_valid && (state_r == S_IDLE);

  pkht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .req   (in_word),
    .res   (hres)
  );

  assign ram_rd_en   = (state_r == S_HASH) && hres.done;
  assign ram_wr_en   = (state_r == S_CLEAR) || ((state_r == S_MOD) && bres.wr_en);
  assign ram_wr_addr = (state_r == S_CLEAR) ? clr_r : addr_r;
  assign ram_wr_data = (state_r == S_CLEAR) ? '0 : ROW_W'(row_new);

  pkht_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (hres.bucket),
    .rd_data (rd_row)
  );

  pkht_bucket u_bucket (
    .row     (rd_row),
    .req     (req_r),
    .row_new (row_new),
    .res     (bres)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    addr_nxt      = addr_r;
    req_nxt       = req_r;
    rsp_nxt       = rsp_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BKT_W'(NUM_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_word;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (hres.done) begin
          addr_nxt  = hres.bucket;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        rsp_nxt   = bres.rsp;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = rsp_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r     <= addr_nxt;
    req_r      <= req_nxt;
    rsp_r      <= rsp_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

[hw/rtl/pkht_checker.sv]
// ----------------------------------------------------------------------------
// pkht_checker
// Port-level checks on the hash table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pair_key_hash_table_core_macros.svh"

module pkht_checker import pkht_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire req_t in_word,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire rsp_t out_word
);

  `PKHT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "result word changed while stalled")
  `PKHT_ASSERT_NOW(a_status_code, out_valid, out_word.status != 2'd3, "illegal status code")
  `PKHT_ASSERT_NOW(a_value_zero, out_valid && (out_word.status != ST_OK), out_word.found_value == '0, "value set on a failed request")
  `PKHT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second word taken while busy")

endmodule

bind pair_key_hash_table_core pkht_checker u_pkht_checker (.*);

`default_nettype wire
